>>> rtl/ers_pkg.sv
package ers_pkg;

  localparam int unsigned MaxExtentsDef  = 16;
  localparam int unsigned SectorBytesDef = 512;

  localparam int unsigned SecW     = 48;
  localparam int unsigned CntW     = 32;
  localparam int unsigned OffW     = 48;
  localparam int unsigned LenW     = 32;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ExtCntW  = 5;
  localparam int unsigned BstW     = 9;
  localparam int unsigned BcntW    = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_REQ  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXTENT_COUNT = 1'b0,
    CFG_FILE_SIZE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_HEAD,
    MODE_RUN,
    MODE_TAIL
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_OFF,
    S_HEAD,
    S_DLEN_GO,
    S_DIV_LEN,
    S_SEEK,
    S_CMP,
    S_MAP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [ExtCntW-1:0] extent_count;
    logic [OffW-1:0]    file_size;
  } cfg_t;

  typedef struct packed {
    logic [SecW-1:0]  cmd_sector;
    logic [CntW-1:0]  cmd_sector_count;
    logic             partial;
    logic [BstW-1:0]  byte_start;
    logic [BcntW-1:0] byte_count;
    logic             write_dir;
    logic             error;
    logic             last;
  } result_t;

endpackage

>>> rtl/ers_if.sv
interface ers_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ers_pkg::IdxW-1:0]   entry_index;
  logic [ers_pkg::SecW-1:0]   entry_start_sector;
  logic [ers_pkg::CntW-1:0]   entry_sector_count;
  logic [ers_pkg::OffW-1:0]   request_offset;
  logic [ers_pkg::LenW-1:0]   request_length;
  logic                       is_write;

  modport source (output valid, op, entry_index, entry_start_sector, entry_sector_count,
                  request_offset, request_length, is_write, input ready);
  modport sink (input valid, op, entry_index, entry_start_sector, entry_sector_count,
                request_offset, request_length, is_write, output ready);
endinterface

interface ers_res_if;
  logic                       valid;
  logic                       ready;
  logic [ers_pkg::SecW-1:0]   cmd_sector;
  logic [ers_pkg::CntW-1:0]   cmd_sector_count;
  logic                       partial;
  logic [ers_pkg::BstW-1:0]   byte_start;
  logic [ers_pkg::BcntW-1:0]  byte_count;
  logic                       write_dir;
  logic                       error;
  logic                       last;

  modport source (output valid, cmd_sector, cmd_sector_count, partial, byte_start,
                  byte_count, write_dir, error, last, input ready);
  modport sink (input valid, cmd_sector, cmd_sector_count, partial, byte_start,
                byte_count, write_dir, error, last, output ready);
endinterface

interface ers_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ers_pkg::CfgIdxW-1:0]   index;
  logic [ers_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ers_divider.sv
module ers_divider #(
  parameter int unsigned SECTOR_BYTES = ers_pkg::SectorBytesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ers_pkg::OffW-1:0]         dividend_i,
  output logic                             done_o,
  output logic [ers_pkg::OffW-1:0]         quot_o,
  output logic [$clog2(SECTOR_BYTES)-1:0]  rem_o
);
  import ers_pkg::*;

  localparam int unsigned BW     = $clog2(SECTOR_BYTES);
  localparam int unsigned ChW    = 16;
  localparam int unsigned MW     = OffW + 1;
  localparam int unsigned PW     = OffW + MW;
  localparam bit          IsPow2 = (SECTOR_BYTES & (SECTOR_BYTES - 1)) == 0;
  localparam logic [OffW-1:0] Divisor  = OffW'(SECTOR_BYTES);
  localparam logic [63:0]     MultFull = ((64'd1 << (OffW + BW)) / 64'(SECTOR_BYTES)) + 64'd1;
  localparam logic [MW-1:0]   Mult     = MW'(MultFull);
  localparam logic [2:0]      StepQuot = 3'd3;
  localparam logic [2:0]      StepRem  = 3'd4;

  logic                busy_q;
  logic                done_q;
  logic [2:0]          cnt_q;
  logic [OffW-1:0]     x_q;
  logic [PW-1:0]       acc_q;
  logic [OffW-1:0]     quot_q;
  logic [BW-1:0]       rem_q;
  logic [ChW-1:0]      chunk;
  logic [ChW+MW-1:0]   part;
  logic [OffW-1:0]     qd;

  // reciprocal multiply, one 16-bit slice of the dividend per cycle, msb first
  always_comb begin
    case (cnt_q)
      3'd0:    chunk = x_q[OffW-1:OffW-ChW];
      3'd1:    chunk = x_q[OffW-ChW-1:OffW-2*ChW];
      default: chunk = x_q[ChW-1:0];
    endcase
  end

  assign part = (ChW+MW)'(chunk) * (ChW+MW)'(Mult);
  assign qd   = quot_q * Divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (IsPow2) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepRem) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      acc_q <= '0;
      if (IsPow2) begin
        quot_q <= dividend_i >> BW;
        rem_q  <= dividend_i[BW-1:0];
      end
    end else if (busy_q) begin
      if (cnt_q < StepQuot) begin
        acc_q <= {acc_q[PW-ChW-1:0], {ChW{1'b0}}} + PW'(part);
      end else if (cnt_q == StepQuot) begin
        quot_q <= OffW'(acc_q >> (OffW + BW));
      end else begin
        rem_q <= BW'(x_q - qd);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/ers_extent_ram.sv
module ers_extent_ram #(
  parameter int unsigned DEPTH = ers_pkg::MaxExtentsDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [ers_pkg::SecW-1:0]  wr_start_i,
  input  logic [ers_pkg::CntW-1:0]  wr_len_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [ers_pkg::SecW-1:0]  rd_start_o,
  output logic [ers_pkg::CntW-1:0]  rd_len_o
);
  import ers_pkg::*;

  logic [SecW+CntW-1:0] mem [DEPTH];
  logic [SecW+CntW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_start_i, wr_len_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_start_o = rd_q[SecW+CntW-1:CntW];
  assign rd_len_o   = rd_q[CntW-1:0];

endmodule

>>> rtl/ers_core.sv
module ers_core #(
  parameter int unsigned MAX_EXTENTS  = ers_pkg::MaxExtentsDef,
  parameter int unsigned SECTOR_BYTES = ers_pkg::SectorBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ers_pkg::cfg_t     cfg_i,
  ers_req_if.sink           req_i,
  output logic              res_valid_o,
  output ers_pkg::result_t  res_data_o,
  input  logic              res_take_i
);
  import ers_pkg::*;

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned BW = $clog2(SECTOR_BYTES);
  localparam int unsigned NW = $clog2(SECTOR_BYTES + 1);
  localparam logic [NW-1:0]   SbN = NW'(SECTOR_BYTES);
  localparam logic [LenW-1:0] SbL = LenW'(SECTOR_BYTES);

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             wr_q, wr_d;
  logic [OffW-1:0]  fsec_q, fsec_d;
  logic [BW-1:0]    bis_q, bis_d;
  logic [NW-1:0]    hn_q, hn_d;
  logic             head_last_q, head_last_d;
  logic [LenW-1:0]  lsec_q, lsec_d;
  logic [BW-1:0]    lrem_q, lrem_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [OffW-1:0]  base_q, base_d;
  logic [CntW-1:0]  into_q, into_d;
  logic [CntW-1:0]  ns_q, ns_d;
  logic             fin_q, fin_d;
  result_t          res_q, res_d;

  logic             div_start;
  logic [OffW-1:0]  div_dividend;
  logic             div_done;
  logic [OffW-1:0]  div_quot;
  logic [BW-1:0]    div_rem;

  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [SecW-1:0]  rd_start;
  logic [CntW-1:0]  rd_len;

  logic [CW-1:0]    n_eff;
  logic [OffW:0]    diff;
  logic             range_err;
  logic [NW-1:0]    room;
  logic [OffW-1:0]  into_full;
  logic             hit;
  logic [SecW-1:0]  vol;
  logic [CntW-1:0]  left;
  logic [CntW-1:0]  ns;
  logic [LenW-1:0]  lsec_next;
  result_t          err_res;

  ers_divider #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  ers_extent_ram #(
    .DEPTH(MAX_EXTENTS),
    .AW   (AW)
  ) u_ram (
    .clk_i      (clk_i),
    .wr_en_i    (ram_wr_en),
    .wr_addr_i  (AW'(req_i.entry_index)),
    .wr_start_i (req_i.entry_start_sector),
    .wr_len_i   (req_i.entry_sector_count),
    .rd_en_i    (ram_rd_en),
    .rd_addr_i  (idx_q[AW-1:0]),
    .rd_start_o (rd_start),
    .rd_len_o   (rd_len)
  );

  always_comb begin
    if (32'(cfg_i.extent_count) > MAX_EXTENTS) begin
      n_eff = CW'(MAX_EXTENTS);
    end else begin
      n_eff = CW'(cfg_i.extent_count);
    end
  end

  assign diff      = {1'b0, cfg_i.file_size} - {1'b0, off_q};
  assign range_err = diff[OffW] || (diff[OffW-1:0] < OffW'(len_q));
  assign room      = SbN - NW'(bis_q);
  assign into_full = fsec_q - base_q;
  assign hit       = (into_full[OffW-1:CntW] == '0) && (into_full[CntW-1:0] < rd_len);
  assign vol       = rd_start + SecW'(into_q);
  assign left      = rd_len - into_q;
  assign ns        = (lsec_q < left) ? lsec_q : left;
  assign lsec_next = lsec_q - ns_q;

  always_comb begin
    err_res           = '0;
    err_res.write_dir = wr_q;
    err_res.error     = 1'b1;
    err_res.last      = 1'b1;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign ram_wr_en   = (state_q == S_IDLE) && req_i.valid && (req_i.op == OP_LOAD)
                       && (32'(req_i.entry_index) < MAX_EXTENTS);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    off_d        = off_q;
    len_d        = len_q;
    wr_d         = wr_q;
    fsec_d       = fsec_q;
    bis_d        = bis_q;
    hn_d         = hn_q;
    head_last_d  = head_last_q;
    lsec_d       = lsec_q;
    lrem_d       = lrem_q;
    idx_d        = idx_q;
    base_d       = base_q;
    into_d       = into_q;
    ns_d         = ns_q;
    fin_d        = fin_q;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = off_q;
    ram_rd_en    = 1'b0;
    res_valid_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid && (req_i.op == OP_REQ)) begin
          off_d = req_i.request_offset;
          len_d = req_i.request_length;
          wr_d  = req_i.is_write;
          if (req_i.request_length != '0) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        idx_d  = '0;
        base_d = '0;
        if (range_err) begin
          res_d   = err_res;
          fin_d   = 1'b1;
          state_d = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_OFF;
        end
      end
      S_DIV_OFF: begin
        if (div_done) begin
          fsec_d  = div_quot;
          bis_d   = div_rem;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if ((bis_q != '0) || (len_q < SbL)) begin
          mode_d = MODE_HEAD;
          if (len_q <= LenW'(room)) begin
            hn_d        = len_q[NW-1:0];
            head_last_d = 1'b1;
          end else begin
            hn_d        = room;
            head_last_d = 1'b0;
          end
          state_d = S_SEEK;
        end else begin
          state_d = S_DLEN_GO;
        end
      end
      S_DLEN_GO: begin
        div_start    = 1'b1;
        div_dividend = OffW'(len_q);
        state_d      = S_DIV_LEN;
      end
      S_DIV_LEN: begin
        if (div_done) begin
          lsec_d = div_quot[LenW-1:0];
          lrem_d = div_rem;
          if (div_quot[LenW-1:0] != '0) begin
            mode_d  = MODE_RUN;
            state_d = S_SEEK;
          end else if (div_rem != '0) begin
            mode_d  = MODE_TAIL;
            state_d = S_SEEK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SEEK: begin
        if (idx_q >= n_eff) begin
          res_d   = err_res;
          fin_d   = 1'b1;
          state_d = S_EMIT;
        end else begin
          ram_rd_en = 1'b1;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        if (hit) begin
          into_d  = into_full[CntW-1:0];
          state_d = S_MAP;
        end else begin
          base_d  = base_q + OffW'(rd_len);
          idx_d   = idx_q + 1'b1;
          state_d = S_SEEK;
        end
      end
      S_MAP: begin
        res_d            = '0;
        res_d.cmd_sector = vol;
        res_d.write_dir  = wr_q;
        case (mode_q)
          MODE_HEAD: begin
            res_d.cmd_sector_count = CntW'(1);
            res_d.partial          = 1'b1;
            res_d.byte_start       = BstW'(bis_q);
            res_d.byte_count       = BcntW'(hn_q);
            res_d.last             = head_last_q;
            fin_d                  = head_last_q;
          end
          MODE_RUN: begin
            ns_d                   = ns;
            res_d.cmd_sector_count = ns;
            res_d.last             = (ns == lsec_q) && (lrem_q == '0);
            fin_d                  = (ns == lsec_q) && (lrem_q == '0);
          end
          default: begin
            res_d.cmd_sector_count = CntW'(1);
            res_d.partial          = 1'b1;
            res_d.byte_count       = BcntW'(lrem_q);
            res_d.last             = 1'b1;
            fin_d                  = 1'b1;
          end
        endcase
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          if (fin_q) begin
            state_d = S_IDLE;
          end else begin
            case (mode_q)
              MODE_HEAD: begin
                len_d   = len_q - LenW'(hn_q);
                fsec_d  = fsec_q + 1'b1;
                state_d = S_DLEN_GO;
              end
              MODE_RUN: begin
                fsec_d = fsec_q + OffW'(ns_q);
                lsec_d = lsec_next;
                if (lsec_next == '0) begin
                  mode_d = MODE_TAIL;
                end
                state_d = S_SEEK;
              end
              default: begin
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_HEAD;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q       <= off_d;
    len_q       <= len_d;
    wr_q        <= wr_d;
    fsec_q      <= fsec_d;
    bis_q       <= bis_d;
    hn_q        <= hn_d;
    head_last_q <= head_last_d;
    lsec_q      <= lsec_d;
    lrem_q      <= lrem_d;
    idx_q       <= idx_d;
    base_q      <= base_d;
    into_q      <= into_d;
    ns_q        <= ns_d;
    res_q       <= res_d;
  end

  assign res_data_o = res_q;

endmodule

>>> rtl/extent_request_splitter.sv
// Extent request splitter: maps file byte ranges onto volume sector commands.
// req_i carries transactions of two kinds: a load writes one extent table slot,
// a request (offset, length, direction) is split into commands on res_o, the
// last one flagged. cfg_i writes extent_count and file_size_bytes; it is
// always ready, and the user must see that it is written only while no
// request is in flight; the block itself does not enforce this. A request
// first runs a range check and a division of the offset by the sector size
// in the shared divider (a shift for a power-of-two sector size); a second
// division, of the length left after any head sector, follows unless the
// head sector ends the request. Each command then walks the extent table
// one entry at a time (S_SEEK reads, S_CMP compares) from where the
// previous command stopped, re-reading the entry it stops on, then S_MAP
// builds the command and S_EMIT issues it; req_i is not ready meanwhile.
// Results pass through one output register, so the sequencer can prepare
// the next command while the previous one waits there, and hands it over
// once the register is free or being read; when res_o stalls the
// sequencer holds its command. Reset clears both configuration registers
// and the sequencer; the extent table is undefined until loaded.
module extent_request_splitter #(
  parameter int unsigned MAX_EXTENTS  = ers_pkg::MaxExtentsDef,
  parameter int unsigned SECTOR_BYTES = ers_pkg::SectorBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ers_cfg_if.sink    cfg_i,
  ers_req_if.sink    req_i,
  ers_res_if.source  res_o
);
  import ers_pkg::*;

  logic [ExtCntW-1:0] ext_cnt_q;
  logic [OffW-1:0]    fsize_q;
  cfg_t               cfg;
  logic               core_valid;
  result_t            core_res;
  logic               take;
  logic               out_valid_q;
  result_t            out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_cnt_q <= '0;
      fsize_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_EXTENT_COUNT: ext_cnt_q <= cfg_i.data[ExtCntW-1:0];
        CFG_FILE_SIZE:    fsize_q   <= cfg_i.data[OffW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.extent_count = ext_cnt_q;
  assign cfg.file_size    = fsize_q;

  ers_core #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .res_valid_o (core_valid),
    .res_data_o  (core_res),
    .res_take_i  (take)
  );

  assign take = core_valid && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.cmd_sector       = out_q.cmd_sector;
  assign res_o.cmd_sector_count = out_q.cmd_sector_count;
  assign res_o.partial          = out_q.partial;
  assign res_o.byte_start       = out_q.byte_start;
  assign res_o.byte_count       = out_q.byte_count;
  assign res_o.write_dir        = out_q.write_dir;
  assign res_o.error            = out_q.error;
  assign res_o.last             = out_q.last;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.error |-> res_o.last && !res_o.partial && res_o.cmd_sector == '0)
    else $error("error result not terminal or not cleared");

  a_partial_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.partial |-> res_o.cmd_sector_count == 1 && !res_o.error)
    else $error("partial command spans more than one sector");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.error && !res_o.partial |-> res_o.cmd_sector_count != '0)
    else $error("whole-sector run of zero sectors");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.op == OP_REQ && req_i.request_length != '0
    |=> !req_i.ready)
    else $error("ready right after a non-empty request");

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ers_pkg::*;

  localparam int unsigned     NumSlots   = MaxExtentsDef;
  localparam longint unsigned SecBytes   = SectorBytesDef;
  localparam int unsigned     MaxCmds    = NumSlots + 2;
  localparam longint unsigned Mask48     = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned     QuietLimit = 4000;
  localparam int unsigned     SettleCyc  = 200;

  typedef struct {
    op_e             op;
    logic [IdxW-1:0] slot;
    logic [SecW-1:0] start;
    logic [CntW-1:0] count;
    logic [OffW-1:0] offset;
    logic [LenW-1:0] length;
    logic            wr;
  } xact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ers_cfg_if cfg_bus ();
  ers_req_if req_bus ();
  ers_res_if res_bus ();

  extent_request_splitter uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  always #4 clk = ~clk;

  // extent map as the block should hold it
  logic [SecW-1:0]    ext_start [NumSlots];
  logic [CntW-1:0]    ext_len   [NumSlots];
  logic [ExtCntW-1:0] extent_count;
  logic [OffW-1:0]    file_size;

  // slot lengths as queued, used to aim requests at the mapped area
  longint unsigned plan_len [NumSlots];

  result_t expected_cmds[$];
  xact_t   send_queue[$];
  xact_t   cur_xact;
  result_t got_cmd;
  result_t want_cmd;

  int errors = 0;
  int quiet = 0;
  int send_gap;
  int stall;
  bit idle_en = 1'b1;

  function automatic void split_into_commands(xact_t x);
    result_t         cmds[$];
    result_t         c;
    longint unsigned off, len, vol, left, bis, fs, base, n, ns;
    int              k, slots;
    bit              found;
    if (x.op == OP_LOAD) begin
      ext_start[x.slot] = x.start;
      ext_len[x.slot] = x.count;
      return;
    end
    off = x.offset;
    len = x.length;
    if (len == 0) return;
    c = '0;
    c.write_dir = x.wr;
    c.error = 1'b1;
    c.last = 1'b1;
    if (off > file_size || len > file_size - off) begin
      expected_cmds.push_back(c);
      return;
    end
    slots = (extent_count > NumSlots) ? NumSlots : extent_count;
    k = 0;
    while (len > 0 && k < MaxCmds) begin
      bis = off % SecBytes;
      fs = off / SecBytes;
      found = 1'b0;
      base = 0;
      vol = 0;
      left = 0;
      for (int i = 0; i < slots && !found; i++) begin
        if (fs < base + ext_len[i]) begin
          vol = (ext_start[i] + (fs - base)) & Mask48;
          left = ext_len[i] - (fs - base);
          found = 1'b1;
        end else begin
          base += ext_len[i];
        end
      end
      c = '0;
      c.write_dir = x.wr;
      if (!found) begin
        c.error = 1'b1;
        cmds.push_back(c);
        break;
      end
      if (bis != 0 || len < SecBytes) begin
        n = SecBytes - bis;
        if (n > len) n = len;
        c.cmd_sector = SecW'(vol);
        c.cmd_sector_count = CntW'(1);
        c.partial = 1'b1;
        c.byte_start = BstW'(bis);
        c.byte_count = BcntW'(n);
        off += n;
        len -= n;
      end else begin
        ns = len / SecBytes;
        if (ns > left) ns = left;
        c.cmd_sector = SecW'(vol);
        c.cmd_sector_count = CntW'(ns);
        off += ns * SecBytes;
        len -= ns * SecBytes;
      end
      cmds.push_back(c);
      k++;
    end
    cmds[cmds.size()-1].last = 1'b1;
    foreach (cmds[j]) expected_cmds.push_back(cmds[j]);
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("t=%0t %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // request side
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_LOAD;
      req_bus.entry_index <= '0;
      req_bus.entry_start_sector <= '0;
      req_bus.entry_sector_count <= '0;
      req_bus.request_offset <= '0;
      req_bus.request_length <= '0;
      req_bus.is_write <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) split_into_commands(cur_xact);
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (send_queue.size() != 0 && idle_en && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 8);
          req_bus.valid <= 1'b0;
        end else if (send_queue.size() != 0) begin
          cur_xact = send_queue.pop_front();
          req_bus.op <= cur_xact.op;
          req_bus.entry_index <= cur_xact.slot;
          req_bus.entry_start_sector <= cur_xact.start;
          req_bus.entry_sector_count <= cur_xact.count;
          req_bus.request_offset <= cur_xact.offset;
          req_bus.request_length <= cur_xact.length;
          req_bus.is_write <= cur_xact.wr;
          req_bus.valid <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // command side
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      stall <= 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got_cmd.cmd_sector = res_bus.cmd_sector;
        got_cmd.cmd_sector_count = res_bus.cmd_sector_count;
        got_cmd.partial = res_bus.partial;
        got_cmd.byte_start = res_bus.byte_start;
        got_cmd.byte_count = res_bus.byte_count;
        got_cmd.write_dir = res_bus.write_dir;
        got_cmd.error = res_bus.error;
        got_cmd.last = res_bus.last;
        if (expected_cmds.size() == 0) begin
          $display("t=%0t unexpected command: expected none actual %p", $time, got_cmd);
          errors++;
        end else begin
          want_cmd = expected_cmds.pop_front();
          check_field("cmd_sector", want_cmd.cmd_sector, got_cmd.cmd_sector);
          check_field("cmd_sector_count", want_cmd.cmd_sector_count,
                      got_cmd.cmd_sector_count);
          check_field("partial", want_cmd.partial, got_cmd.partial);
          check_field("byte_start", want_cmd.byte_start, got_cmd.byte_start);
          check_field("byte_count", want_cmd.byte_count, got_cmd.byte_count);
          check_field("write_dir", want_cmd.write_dir, got_cmd.write_dir);
          check_field("error", want_cmd.error, got_cmd.error);
          check_field("last", want_cmd.last, got_cmd.last);
        end
      end
      if (stall != 0) begin
        stall <= stall - 1;
        res_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall <= $urandom_range(0, 8);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("** extent_request_splitter: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input longint unsigned value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value[CfgDataW-1:0];
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_EXTENT_COUNT) extent_count = value[ExtCntW-1:0];
    else file_size = value[OffW-1:0];
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_load(input int slot, input longint unsigned start,
                            input longint unsigned count);
    xact_t x;
    x = '{OP_LOAD, slot[IdxW-1:0], start[SecW-1:0], count[CntW-1:0], '0, '0, 1'b0};
    send_queue.push_back(x);
    plan_len[slot] = count[CntW-1:0];
  endtask

  task automatic queue_req(input longint unsigned off, input longint unsigned len,
                           input bit wr);
    xact_t x;
    x = '{OP_REQ, '0, '0, '0, off[OffW-1:0], len[LenW-1:0], wr};
    send_queue.push_back(x);
  endtask

  task automatic drain();
    while (send_queue.size() != 0 || req_bus.valid) @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  function automatic longint unsigned mapped_bytes();
    longint unsigned sum;
    int              slots;
    sum = 0;
    slots = (extent_count > NumSlots) ? NumSlots : extent_count;
    for (int i = 0; i < slots; i++) sum += plan_len[i];
    return sum * SecBytes;
  endfunction

  task automatic random_traffic(input int n);
    longint unsigned off, len, lim;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 19))
          0:       len = 0;
          1:       len = $urandom;
          default: len = $urandom_range(1, 8);
        endcase
        queue_load($urandom_range(0, NumSlots - 1), {$urandom, $urandom} & Mask48, len);
      end else begin
        lim = mapped_bytes();
        lim = ((lim > 40000) ? 40000 : lim) + 1024;
        case ($urandom_range(0, 9))
          0:       off = {$urandom, $urandom} & Mask48;
          1:       off = (file_size >= 700) ? file_size - $urandom_range(0, 700)
                                            : $urandom_range(0, 700);
          default: off = {$urandom, $urandom} % lim;
        endcase
        if ($urandom_range(0, 3) == 0) off = off & ~(SecBytes - 1);
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom;
          2:       len = $urandom_range(1, 24) * SecBytes;
          3:       len = $urandom_range(1, 40000);
          default: len = $urandom_range(1, 6000);
        endcase
        queue_req(off, len, $urandom_range(0, 1));
      end
    end
  endtask

  int              phase_count [8] = '{16, 31, 0, 1, -1, 16, -1, 16};
  int              phase_items [8] = '{60, 60, 40, 40, 60, 60, 60, 60};
  longint unsigned size_val;

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_EXTENT_COUNT;
    cfg_bus.data = '0;
    extent_count = '0;
    file_size = '0;
    foreach (plan_len[i]) plan_len[i] = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty map, zero file size
    queue_req(0, 1, 1'b1);
    queue_req(0, 0, 1'b0);
    queue_req(Mask48, 32'hFFFF_FFFF, 1'b1);
    drain();

    write_reg(CFG_EXTENT_COUNT, 16);
    write_reg(CFG_FILE_SIZE, Mask48);
    queue_load(0, Mask48 - 1, 3);
    queue_load(1, {$urandom, $urandom} & Mask48, 0);
    for (int s = 2; s < NumSlots - 1; s++)
      queue_load(s, {$urandom, $urandom} & Mask48, $urandom_range(1, 4));
    queue_load(NumSlots - 1, {$urandom, $urandom} & Mask48, 32'hFFFF_FFFF);
    queue_req(5, 10, 1'b1);
    queue_req(500, 30, 1'b0);
    queue_req(2 * SecBytes, SecBytes, 1'b1);
    queue_req(100, 60 * SecBytes, 1'b0);
    queue_req(0, 32'hFFFF_FFFF, 1'b1);
    queue_req(Mask48, 1, 1'b0);
    queue_req(Mask48 - 511, SecBytes, 1'b1);
    queue_req((64'd1 << 40) + 7, 600, 1'b0);
    queue_req(3 * SecBytes, 0, 1'b1);
    drain();
    queue_load(NumSlots - 1, {$urandom, $urandom} & Mask48, 5);

    for (int p = 0; p < 8; p++) begin
      idle_en = (p != 7);
      write_reg(CFG_EXTENT_COUNT, (phase_count[p] < 0) ? $urandom_range(2, 15)
                                                       : phase_count[p]);
      case (p)
        0, 6, 7: size_val = Mask48;
        1, 5:    size_val = mapped_bytes() + $urandom_range(0, 2000);
        2:       size_val = 0;
        3:       size_val = $urandom_range(1, 4096);
        default: size_val = {$urandom, $urandom} & Mask48;
      endcase
      write_reg(CFG_FILE_SIZE, size_val);
      random_traffic(phase_items[p]);
      drain();
    end

    if (errors == 0) begin
      $display("** extent_request_splitter: PASSED **");
    end else begin
      $display("** extent_request_splitter: FAILED **");
    end
    $finish;
  end

endmodule

>>> extent_request_splitter.f
rtl/ers_pkg.sv
rtl/ers_if.sv
rtl/ers_divider.sv
rtl/ers_extent_ram.sv
rtl/ers_core.sv
rtl/extent_request_splitter.sv
tb/testbench.sv
